// File: sv/mtt_pkg.sv
package mtt_pkg;

    // Most expiries reported for one tick
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [31:0] NONE_ACTIVE = 32'hFFFF_FFFF;

    // Operation codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // Entry modes
    localparam logic [1:0] MODE_FREE     = 2'd0;
    localparam logic [1:0] MODE_ONESHOT  = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  owner_id;
        logic [7:0]  signal_num;
        logic        kind;
        logic [31:0] duration;
        logic        periodic;
        logic [31:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic        expired_valid;
        logic [7:0]  expired_owner;
        logic [7:0]  expired_signal;
        logic        expired_kind;
        logic        last;
        logic [31:0] next_timeout;
    } t_res;

    typedef struct packed {
        logic [31:0] remaining;
        logic [31:0] reload;
        logic [7:0]  owner;
        logic [7:0]  signal_num;
        logic        kind;
    } t_entry;

endpackage

// File: sv/multi_timer_table.sv
// Timer table of ENTRIES timers keyed by owner and signal. A command is taken on
// i_start while o_busy is low; its results appear on o_res, each for exactly one
// cycle with o_res_valid high, and cannot be held off, so the receiver must take
// every strobe. Start, stop and unused codes give one result; a tick gives one
// result per expired entry in entry order (at most MAX_RESULTS reported, all
// expiries still applied), or one plain result if nothing expired. The last result
// of a command carries last = 1, and every result of it carries the same
// next_timeout, the smallest remaining time after the command, all ones when the
// table is empty. Timing: o_busy stays high while the entry memory is walked one
// read a cycle, and for a tick with reported expiries also while each reported
// entry is read again and its report registered. Each expiry report passes
// through r_rdata and the result register after its entry is addressed, and the
// reports of one tick come on consecutive cycles. The last result of a command is
// strobed in the first cycle with o_busy low; a new command may be given in that
// same cycle.
module multi_timer_table
    import mtt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    output logic o_busy,
    output logic o_res_valid,
    output t_res o_res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0]    LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;

    // Entry memory: one read port, one write port, registered read data
    t_entry tbl_mem [ENTRIES];
    t_entry r_rdata;

    // Per-entry mode in flops, cleared by reset (free)
    logic [1:0] r_mode [ENTRIES];

    logic [IW-1:0]      r_idx;      // read issue pointer
    logic [IW-1:0]      r_didx;     // index of the entry in r_rdata
    logic               r_issue;
    logic               r_dv;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic               r_hit_kind;
    logic [31:0]        r_min;
    logic [ENTRIES-1:0] r_exp;      // expired entries still to report
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend;
    logic               r_pend_last;
    logic [31:0]        r_nt;
    t_res               r_res;
    logic               r_res_valid;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_entry             wr_data;

    logic               free_any;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      exp_idx;
    logic [ENTRIES-1:0] exp_rest;

    logic               d_active;
    logic               d_periodic;
    logic [31:0]        d_sub;
    logic               d_zero;
    logic [31:0]        n_rem;
    logic               d_keep;
    logic               d_match;
    logic [31:0]        d_cand;
    logic               d_cand_en;

    logic               fin_write;
    logic [IW-1:0]      fin_slot;
    logic [31:0]        fin_nt;

    // Lowest free entry
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_mode[i] == MODE_FREE) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // Lowest expired entry not yet reported
    always_comb begin
        exp_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_exp[i]) begin
                exp_idx = IW'(i);
            end
        end
        exp_rest = r_exp & ~(ENTRIES'(1) << exp_idx);
    end

    // Walk data stage: entry r_didx is in r_rdata
    always_comb begin
        d_active   = (r_mode[r_didx] != MODE_FREE);
        d_periodic = (r_mode[r_didx] == MODE_PERIODIC);
        d_sub      = (r_rdata.remaining > r_cmd.elapsed) ?
                     (r_rdata.remaining - r_cmd.elapsed) : '0;
        d_zero     = (d_sub == '0);
        n_rem      = d_zero ? r_rdata.reload : d_sub;
        d_keep     = !d_zero || d_periodic;
        d_match    = d_active
                  && (r_rdata.owner == r_cmd.owner_id)
                  && (r_rdata.signal_num == r_cmd.signal_num)
                  && ((r_cmd.func == FUNC_START) || (r_cmd.func == FUNC_STOP));
        if (r_cmd.func == FUNC_TICK) begin
            d_cand    = n_rem;
            d_cand_en = d_active && d_keep;
        end else begin
            // matched entry is rewritten or freed; handled at the end
            d_cand    = r_rdata.remaining;
            d_cand_en = d_active && !d_match;
        end
    end

    // End of walk for a start: re-arm the match or take the lowest free entry
    always_comb begin
        fin_write = (r_cmd.func == FUNC_START) && (r_hit || free_any);
        fin_slot  = r_hit ? r_hit_idx : free_idx;
        fin_nt    = (fin_write && (r_cmd.duration < r_min)) ? r_cmd.duration : r_min;
    end

    // Memory port steering
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        if ((r_state == S_WALK) && r_issue) begin
            rd_en   = 1'b1;
            rd_addr = r_idx;
        end else if ((r_state == S_EMIT) && (r_exp != '0)) begin
            rd_en   = 1'b1;
            rd_addr = exp_idx;
        end

        wr_en   = 1'b0;
        wr_addr = r_didx;
        wr_data = r_rdata;
        if ((r_state == S_WALK) && r_dv && (r_cmd.func == FUNC_TICK)
                && d_active && d_keep) begin
            wr_en             = 1'b1;
            wr_addr           = r_didx;
            wr_data.remaining = n_rem;
        end else if ((r_state == S_FIN) && fin_write) begin
            wr_en              = 1'b1;
            wr_addr            = fin_slot;
            wr_data.remaining  = r_cmd.duration;
            wr_data.reload     = r_cmd.periodic ? r_cmd.duration : '0;
            wr_data.owner      = r_cmd.owner_id;
            wr_data.signal_num = r_cmd.signal_num;
            wr_data.kind       = r_hit ? r_hit_kind : r_cmd.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= tbl_mem[rd_addr];
        end
    end

    // Control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
            r_exp       <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_mode[i] <= MODE_FREE;
            end
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                        r_dv    <= 1'b0;
                        r_min   <= NONE_ACTIVE;
                        r_hit   <= 1'b0;
                        r_exp   <= '0;
                        r_state <= S_WALK;
                    end
                end

                S_WALK: begin
                    r_dv   <= r_issue;
                    r_didx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        if (d_cand_en && (d_cand < r_min)) begin
                            r_min <= d_cand;
                        end
                        if ((r_cmd.func == FUNC_TICK) && d_active && d_zero) begin
                            r_exp[r_didx] <= 1'b1;
                            if (!d_periodic) begin
                                r_mode[r_didx] <= MODE_FREE;
                            end
                        end
                        if (d_match) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_didx;
                            r_hit_kind <= r_rdata.kind;
                        end
                        if (r_didx == LAST_IDX) begin
                            r_state <= S_FIN;
                        end
                    end
                end

                S_FIN: begin
                    r_res.status         <= ST_DONE;
                    r_res.expired_valid  <= 1'b0;
                    r_res.expired_owner  <= '0;
                    r_res.expired_signal <= '0;
                    r_res.expired_kind   <= 1'b0;
                    r_res.last           <= 1'b1;
                    r_res.next_timeout   <= fin_nt;
                    if (r_cmd.func == FUNC_START) begin
                        if (fin_write) begin
                            r_mode[fin_slot] <= r_cmd.periodic ? MODE_PERIODIC
                                                               : MODE_ONESHOT;
                        end else begin
                            r_res.status <= ST_FULL;
                        end
                    end else if (r_cmd.func == FUNC_STOP) begin
                        if (r_hit) begin
                            r_mode[r_hit_idx] <= MODE_FREE;
                        end else begin
                            r_res.status <= ST_NOMATCH;
                        end
                    end
                    if ((r_cmd.func == FUNC_TICK) && (r_exp != '0)) begin
                        r_nt    <= r_min;
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                S_EMIT: begin
                    // read one expired entry a cycle, report it the cycle after
                    r_pend <= 1'b0;
                    if (r_exp != '0) begin
                        r_pend      <= 1'b1;
                        r_pend_last <= (exp_rest == '0) || (r_cnt == LAST_CNT);
                        r_cnt       <= r_cnt + 1'b1;
                        r_exp       <= (r_cnt == LAST_CNT) ? '0 : exp_rest;
                    end
                    if (r_pend) begin
                        r_res_valid          <= 1'b1;
                        r_res.status         <= ST_DONE;
                        r_res.expired_valid  <= 1'b1;
                        r_res.expired_owner  <= r_rdata.owner;
                        r_res.expired_signal <= r_rdata.signal_num;
                        r_res.expired_kind   <= r_rdata.kind;
                        r_res.last           <= r_pend_last;
                        r_res.next_timeout   <= r_nt;
                        if (r_pend_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
